### rtl/vn2_pkg.sv
package vn2_pkg;

  localparam int COMP_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int UNIT_W    = 16;

  typedef struct packed {
    logic signed [COMP_W-1:0] x_component;
    logic signed [COMP_W-1:0] y_component;
  } vn2_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic                     success;
  } vn2_out_t;

  // per-word control that travels down the pipe
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic zero;
  } vn2_ctl_t;

endpackage

### rtl/vn2_cell.sv
// One quotient bit for both lanes. P tracks d^2*s and Q tracks d*s, d = 2q-1.
module vn2_cell #(
  parameter int PW  = 70,
  parameter int QW  = 15,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vn2_pkg::vn2_ctl_t    ctl_i,
  input  logic signed [PW-1:0] s_i,
  input  logic signed [PW-1:0] rhs_x_i,
  input  logic signed [PW-1:0] rhs_y_i,
  input  logic [QW-1:0]        qx_i,
  input  logic signed [PW-1:0] px_i,
  input  logic signed [PW-1:0] qsx_i,
  input  logic [QW-1:0]        qy_i,
  input  logic signed [PW-1:0] py_i,
  input  logic signed [PW-1:0] qsy_i,
  output vn2_pkg::vn2_ctl_t    ctl_o,
  output logic signed [PW-1:0] s_o,
  output logic signed [PW-1:0] rhs_x_o,
  output logic signed [PW-1:0] rhs_y_o,
  output logic [QW-1:0]        qx_o,
  output logic signed [PW-1:0] px_o,
  output logic signed [PW-1:0] qsx_o,
  output logic [QW-1:0]        qy_o,
  output logic signed [PW-1:0] py_o,
  output logic signed [PW-1:0] qsy_o
);
  import vn2_pkg::*;

  vn2_ctl_t ctl_r;
  logic signed [PW-1:0] s_r, rhs_x_r, rhs_y_r, px_r, qsx_r, py_r, qsy_r;
  logic signed [PW-1:0] px_nxt, qsx_nxt, py_nxt, qsy_nxt;
  logic signed [PW-1:0] cx, cy;
  logic [QW-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic [QW-1:0] bit_mask;

  assign bit_mask = QW'(1) << BIT;

  always_comb begin
    cx = px_i + (qsx_i <<< (BIT + 2)) + (s_i <<< (2 * BIT + 2));
    cy = py_i + (qsy_i <<< (BIT + 2)) + (s_i <<< (2 * BIT + 2));
    qx_nxt = qx_i; px_nxt = px_i; qsx_nxt = qsx_i;
    qy_nxt = qy_i; py_nxt = py_i; qsy_nxt = qsy_i;
    if (cx <= rhs_x_i) begin
      qx_nxt  = qx_i | bit_mask;
      px_nxt  = cx;
      qsx_nxt = qsx_i + (s_i <<< (BIT + 1));
    end
    if (cy <= rhs_y_i) begin
      qy_nxt  = qy_i | bit_mask;
      py_nxt  = cy;
      qsy_nxt = qsy_i + (s_i <<< (BIT + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    s_r <= s_i; rhs_x_r <= rhs_x_i; rhs_y_r <= rhs_y_i;
    qx_r <= qx_nxt; px_r <= px_nxt; qsx_r <= qsx_nxt;
    qy_r <= qy_nxt; py_r <= py_nxt; qsy_r <= qsy_nxt;
  end

  assign ctl_o = ctl_r;
  assign s_o = s_r;
  assign rhs_x_o = rhs_x_r;
  assign rhs_y_o = rhs_y_r;
  assign qx_o = qx_r;
  assign px_o = px_r;
  assign qsx_o = qsx_r;
  assign qy_o = qy_r;
  assign py_o = py_r;
  assign qsy_o = qsy_r;
endmodule

### rtl/vector_normalize_2d.sv
// Channel | Ports                    | Handshake
// input   | start, busy, in_word     | taken when start && !busy
// result  | out_valid, out_word      | one-cycle strobe, no backpressure
// One word per clock while busy is low; the pipe has three front stages
// (magnitude, squares, length^2), one cell per quotient bit, one output stage.
// busy is set by reset and clears at the first clock after reset is released; results cannot be stalled.
// Reset clears the control pipe and sets busy; the data registers are not reset.
module vector_normalize_2d #(
  parameter int FRACTION_BITS = vn2_pkg::FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  vn2_pkg::vn2_in_t in_word,
  output logic             out_valid,
  output vn2_pkg::vn2_out_t out_word
);
  import vn2_pkg::*;

  localparam int QW = FRACTION_BITS + 1;
  localparam int PW = 2 * COMP_W + 2 * FRACTION_BITS + 6;
  localparam int NC = FRACTION_BITS + 1;
  localparam int XW = (QW > UNIT_W) ? QW + 1 : UNIT_W;

  logic busy_r;
  vn2_ctl_t c0_r, c1_r, c2_r, out_ctl_r;
  logic [COMP_W-1:0] ax_r, ay_r;
  logic [2*COMP_W-1:0] ax2_r, ay2_r;
  logic signed [PW-1:0] s2_r, rx2_r, ry2_r;
  logic signed [COMP_W:0] xs, ys;
  logic [XW-1:0] ux_nxt, uy_nxt, qx_ext, qy_ext;
  vn2_out_t out_r;

  vn2_ctl_t ctl_a [NC+1];
  logic signed [PW-1:0] s_a [NC+1], rx_a [NC+1], ry_a [NC+1];
  logic signed [PW-1:0] px_a [NC+1], qsx_a [NC+1], py_a [NC+1], qsy_a [NC+1];
  logic [QW-1:0] qx_a [NC+1], qy_a [NC+1];

  assign xs = {in_word.x_component[COMP_W-1], in_word.x_component};
  assign ys = {in_word.y_component[COMP_W-1], in_word.y_component};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      c0_r <= '0; c1_r <= '0; c2_r <= '0;
    end else begin
      busy_r <= 1'b0;
      c0_r.valid <= start && !busy_r;
      c0_r.neg_x <= in_word.x_component[COMP_W-1];
      c0_r.neg_y <= in_word.y_component[COMP_W-1];
      c0_r.zero  <= (in_word.x_component == '0) && (in_word.y_component == '0);
      c1_r <= c0_r;
      c2_r <= c1_r;
    end
    ax_r  <= COMP_W'(xs[COMP_W] ? -xs : xs);
    ay_r  <= COMP_W'(ys[COMP_W] ? -ys : ys);
    ax2_r <= ax_r * ax_r;
    ay2_r <= ay_r * ay_r;
    s2_r  <= PW'(ax2_r) + PW'(ay2_r);
    rx2_r <= PW'(ax2_r) <<< (2 * FRACTION_BITS + 2);
    ry2_r <= PW'(ay2_r) <<< (2 * FRACTION_BITS + 2);
  end

  // q = 0: d = -1, P = s, Q = -s
  assign ctl_a[0] = c2_r;
  assign s_a[0] = s2_r;
  assign rx_a[0] = rx2_r;
  assign ry_a[0] = ry2_r;
  assign qx_a[0] = '0;
  assign qy_a[0] = '0;
  assign px_a[0] = s2_r;
  assign py_a[0] = s2_r;
  assign qsx_a[0] = -s2_r;
  assign qsy_a[0] = -s2_r;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    vn2_cell #(.PW(PW), .QW(QW), .BIT(FRACTION_BITS - i)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl_i(ctl_a[i]), .s_i(s_a[i]), .rhs_x_i(rx_a[i]), .rhs_y_i(ry_a[i]),
      .qx_i(qx_a[i]), .px_i(px_a[i]), .qsx_i(qsx_a[i]),
      .qy_i(qy_a[i]), .py_i(py_a[i]), .qsy_i(qsy_a[i]),
      .ctl_o(ctl_a[i+1]), .s_o(s_a[i+1]), .rhs_x_o(rx_a[i+1]), .rhs_y_o(ry_a[i+1]),
      .qx_o(qx_a[i+1]), .px_o(px_a[i+1]), .qsx_o(qsx_a[i+1]),
      .qy_o(qy_a[i+1]), .py_o(py_a[i+1]), .qsy_o(qsy_a[i+1])
    );
  end

  always_comb begin
    qx_ext = XW'(qx_a[NC]);
    qy_ext = XW'(qy_a[NC]);
    ux_nxt = ctl_a[NC].neg_x ? -qx_ext : qx_ext;
    uy_nxt = ctl_a[NC].neg_y ? -qy_ext : qy_ext;
    if (ctl_a[NC].zero) begin
      ux_nxt = '0;
      uy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else begin
      out_ctl_r <= ctl_a[NC];
    end
    out_r.unit_x  <= ux_nxt[UNIT_W-1:0];
    out_r.unit_y  <= uy_nxt[UNIT_W-1:0];
    out_r.success <= !ctl_a[NC].zero;
  end

  assign busy = busy_r;
  assign out_valid = out_ctl_r.valid;
  assign out_word = out_r;
endmodule

### rtl/vn2_checker.sv
module vn2_checker #(
  parameter int LAT = vn2_pkg::FRAC_BITS + 5
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input vn2_pkg::vn2_in_t  in_word,
  input logic              out_valid,
  input vn2_pkg::vn2_out_t out_word
);
  import vn2_pkg::*;

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without accepted word");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("accepted word produced no result strobe");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.success |-> out_word.unit_x == '0 && out_word.unit_y == '0)
    else $error("failed normalize with nonzero components");

  a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_word.x_component == '0 && in_word.y_component == '0, LAT)
    |-> !out_word.success)
    else $error("zero vector reported success");

  a_nonzero_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_word.x_component != '0, LAT) |-> out_word.success)
    else $error("nonzero vector reported failure");
endmodule

bind vector_normalize_2d vn2_checker #(.LAT(FRACTION_BITS + 5)) u_vn2_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
  .out_valid(out_valid), .out_word(out_word)
);
